>>> src/mkd_pkg.sv
// shared types, codes and the morse code table for the key timing decoder
package mkd_pkg;

  localparam int TICK_W = 16;
  localparam int CODE_BITS_W = 6;
  localparam int CODE_LEN_W = 3;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_DOT_MIN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DOT_MAX = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DASH_MAX = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPACE_GAP = 2'd3;

  localparam logic [TICK_W-1:0] DOT_MIN_RST = 16'd1000;
  localparam logic [TICK_W-1:0] DOT_MAX_RST = 16'd15000;
  localparam logic [TICK_W-1:0] DASH_MAX_RST = 16'd65000;
  localparam logic [TICK_W-1:0] SPACE_GAP_RST = 16'd40000;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_SPACE = 2'd1;
  localparam logic [1:0] EV_DOT = 2'd2;
  localparam logic [1:0] EV_DASH = 2'd3;

  localparam logic [7:0] UNK = "?";

  localparam logic [7:0] CODE_TABLE [64] = '{
    "E", "T",
    "I", "A", "N", "M",
    "S", "U", "R", "W", "D", "K", "G", "O",
    "H", "V", "F", UNK, "L", UNK, "P", "J",
    "B", "X", "C", "Y", "Z", "Q", UNK, UNK,
    "5", "4", UNK, "3", UNK, UNK, UNK, "2",
    UNK, UNK, UNK, UNK, UNK, UNK, UNK, "1",
    "6", UNK, UNK, UNK, UNK, UNK, UNK, UNK,
    "7", UNK, UNK, UNK, "8", UNK, "9", "0",
    UNK, UNK
  };

  typedef struct packed {
    logic [1:0] event_code;
    logic       dot_on;
    logic       dash_on;
  } mkd_sym_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] code;
    logic [1:0] event_code;
    logic       dot_on;
    logic       dash_on;
  } mkd_char_t;

  function automatic logic [6:0] decode(input logic [CODE_LEN_W-1:0] len,
                                        input logic [CODE_BITS_W-1:0] bits);
    logic [6:0] base;
    logic [5:0] mask;
    logic [5:0] idx;
    logic [7:0] ch;
    base = (7'd1 << len) - 7'd2;
    mask = base[5:0] + 6'd1;
    idx = base[5:0] + (bits & mask);
    ch = CODE_TABLE[idx];
    if (len == 3'd0 || len > 3'd5) begin
      decode = UNK[6:0];
    end else begin
      decode = ch[6:0];
    end
  endfunction

endpackage

>>> src/mkd_fifo.sv
// small flop based queue with registered entries
module mkd_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/mkd_front.sv
// front end: key edge timing, thresholds, dot/dash/space classification and lamps
module mkd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           key_level,
  input  logic                           cfg_wr_en,
  input  logic [mkd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mkd_pkg::TICK_W-1:0]     cfg_wdata,
  output mkd_pkg::mkd_sym_t              sym
);
  import mkd_pkg::*;

  logic [TICK_W-1:0] dot_min, dot_max, dash_max, space_gap;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [TICK_W-1:0] press_length, press_length_next;
  logic last_level, last_level_next;
  logic press_pending, press_pending_next;
  logic key_released, key_released_next;
  logic space_reported, space_reported_next;
  logic count_overflowed, count_overflowed_next;
  logic press_overflowed, press_overflowed_next;
  logic dot_lamp_reg, dot_lamp_reg_next;
  logic dash_lamp_reg, dash_lamp_reg_next;
  logic [1:0] event_code;

  always_comb begin
    tick_count_next = tick_count;
    press_length_next = press_length;
    last_level_next = last_level;
    press_pending_next = press_pending;
    key_released_next = key_released;
    space_reported_next = space_reported;
    count_overflowed_next = count_overflowed;
    press_overflowed_next = press_overflowed;
    dot_lamp_reg_next = dot_lamp_reg;
    dash_lamp_reg_next = dash_lamp_reg;
    event_code = EV_NONE;

    if (key_level != last_level) begin
      if (key_level) begin
        press_pending_next = 1'b1;
        key_released_next = 1'b0;
        press_length_next = '0;
        press_overflowed_next = 1'b0;
        dot_lamp_reg_next = 1'b0;
        dash_lamp_reg_next = 1'b0;
      end else begin
        key_released_next = 1'b1;
        press_length_next = tick_count;
        press_overflowed_next = count_overflowed;
      end
      tick_count_next = '0;
      count_overflowed_next = 1'b0;
      last_level_next = key_level;
    end else begin
      tick_count_next = tick_count + 1'b1;
      if (tick_count == '1) begin
        count_overflowed_next = 1'b1;
      end
    end

    if (tick_count_next >= space_gap && !count_overflowed_next && key_released_next &&
        !space_reported_next) begin
      space_reported_next = 1'b1;
      dot_lamp_reg_next = 1'b0;
      dash_lamp_reg_next = 1'b0;
      event_code = EV_SPACE;
    end else if (!count_overflowed_next && press_pending_next) begin
      if (press_overflowed_next) begin
        press_pending_next = 1'b0;
      end else if (dot_min <= press_length_next && press_length_next <= dot_max) begin
        event_code = EV_DOT;
      end else if (dot_max < press_length_next && press_length_next <= dash_max) begin
        event_code = EV_DASH;
      end
      if (event_code == EV_DOT || event_code == EV_DASH) begin
        press_pending_next = 1'b0;
        space_reported_next = 1'b0;
        dot_lamp_reg_next = (event_code == EV_DOT);
        dash_lamp_reg_next = (event_code == EV_DASH);
      end
    end

    sym.event_code = event_code;
    sym.dot_on = dot_lamp_reg_next;
    sym.dash_on = dash_lamp_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min <= DOT_MIN_RST;
      dot_max <= DOT_MAX_RST;
      dash_max <= DASH_MAX_RST;
      space_gap <= SPACE_GAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DOT_MIN:   dot_min <= cfg_wdata;
        REG_DOT_MAX:   dot_max <= cfg_wdata;
        REG_DASH_MAX:  dash_max <= cfg_wdata;
        REG_SPACE_GAP: space_gap <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      press_length <= '0;
      last_level <= 1'b0;
      press_pending <= 1'b0;
      key_released <= 1'b1;
      space_reported <= 1'b0;
      count_overflowed <= 1'b0;
      press_overflowed <= 1'b0;
      dot_lamp_reg <= 1'b0;
      dash_lamp_reg <= 1'b0;
    end else if (accept) begin
      tick_count <= tick_count_next;
      press_length <= press_length_next;
      last_level <= last_level_next;
      press_pending <= press_pending_next;
      key_released <= key_released_next;
      space_reported <= space_reported_next;
      count_overflowed <= count_overflowed_next;
      press_overflowed <= press_overflowed_next;
      dot_lamp_reg <= dot_lamp_reg_next;
      dash_lamp_reg <= dash_lamp_reg_next;
    end
  end

endmodule

>>> src/mkd_back.sv
// back end: symbol assembly and character lookup
module mkd_back #(
  parameter int MAX_SYMBOLS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  mkd_pkg::mkd_sym_t  sym,
  output mkd_pkg::mkd_char_t result
);
  import mkd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SYMBOLS);

  logic [CNT_W-1:0]       symbol_count, symbol_count_next;
  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic                   emit;
  logic [CNT_W-1:0]       look_len;
  logic [MAX_SYMBOLS-1:0] look_bits;
  logic [6:0]             ch;

  always_comb begin
    symbol_count_next = symbol_count;
    symbol_bits_next = symbol_bits;
    emit = 1'b0;
    look_len = symbol_count;
    look_bits = symbol_bits;
    case (sym.event_code)
      EV_SPACE: begin
        if (symbol_count != '0) begin
          emit = 1'b1;
          symbol_count_next = '0;
          symbol_bits_next = '0;
        end
      end
      EV_DOT, EV_DASH: begin
        look_len = symbol_count + 1'b1;
        look_bits = MAX_SYMBOLS'({symbol_bits, (sym.event_code == EV_DASH)});
        symbol_count_next = look_len;
        symbol_bits_next = look_bits;
        if (look_len >= MAX_CNT) begin
          emit = 1'b1;
          symbol_count_next = '0;
          symbol_bits_next = '0;
        end
      end
      default: begin
      end
    endcase
    ch = decode(CODE_LEN_W'(look_len), CODE_BITS_W'(look_bits));
    result.valid = emit;
    result.code = emit ? ch : 7'd0;
    result.event_code = sym.event_code;
    result.dot_on = sym.dot_on;
    result.dash_on = sym.dash_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      symbol_bits <= '0;
    end else if (fire) begin
      symbol_count <= symbol_count_next;
      symbol_bits <= symbol_bits_next;
    end
  end

endmodule

>>> src/morse_key_timing_decoder.sv
// Morse key timing decoder: takes one sampled key level per timer tick and gives one
// result item per tick (character, symbol event and lamp levels). One item is taken
// every clock cycle while full is low; a result waits in the middle queue before the
// symbol assembler writes it to the output queue. The front end's tick counter and
// classifier carry state between ticks and set the one item per cycle rate; a short
// queue decouples it from the assembler, whose output queue absorbs result stalls.
module morse_key_timing_decoder #(
  parameter int MAX_SYMBOLS = 5,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           key_level,
  input  logic                           pop,
  output logic                           empty,
  output logic                           char_valid,
  output logic [6:0]                     char_code,
  output logic [1:0]                     symbol_event,
  output logic                           dot_lamp,
  output logic                           dash_lamp,
  input  logic                           cfg_wr_en,
  input  logic [mkd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mkd_pkg::TICK_W-1:0]     cfg_wdata
);
  import mkd_pkg::*;

  localparam int SYM_W = $bits(mkd_sym_t);
  localparam int CHAR_W = $bits(mkd_char_t);

  mkd_sym_t  front_sym;
  mkd_sym_t  mid_sym;
  mkd_char_t back_char;
  mkd_char_t out_char;
  logic      accept;
  logic      mid_empty;
  logic      out_full;
  logic      fire;

  assign accept = push && !full;
  assign fire = !mid_empty && !out_full;

  mkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .key_level (key_level),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sym       (front_sym)
  );

  mkd_fifo #(
    .WIDTH (SYM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_sym),
    .rd_en   (fire),
    .rd_data (mid_sym),
    .full    (full),
    .empty   (mid_empty)
  );

  mkd_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .sym    (mid_sym),
    .result (back_char)
  );

  mkd_fifo #(
    .WIDTH (CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire),
    .wr_data (back_char),
    .rd_en   (pop),
    .rd_data (out_char),
    .full    (out_full),
    .empty   (empty)
  );

  assign char_valid = out_char.valid;
  assign char_code = out_char.code;
  assign symbol_event = out_char.event_code;
  assign dot_lamp = out_char.dot_on;
  assign dash_lamp = out_char.dash_on;

endmodule
